/* rtl/bvpc_pkg.sv */
package bvpc_pkg;

  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned RuleBitsDef     = 64;
  localparam int unsigned NumTables       = 5;
  localparam int unsigned NumRules        = 65;
  localparam int unsigned QueueDepth      = 2;

  localparam logic [1:0] FUNC_BYTE  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [2:0] SEL_SRC_ADDR = 3'd0;
  localparam logic [2:0] SEL_DST_ADDR = 3'd1;
  localparam logic [2:0] SEL_PROTO    = 3'd2;
  localparam logic [2:0] SEL_SRC_PORT = 3'd3;
  localparam logic [2:0] SEL_DST_PORT = 3'd4;
  localparam logic [2:0] SEL_ACTION   = 3'd5;

  localparam logic [2:0] REASON_DROP    = 3'd0;
  localparam logic [2:0] REASON_SHORT   = 3'd1;
  localparam logic [2:0] REASON_NOT_IP  = 3'd2;
  localparam logic [2:0] REASON_PROTO   = 3'd3;
  localparam logic [2:0] REASON_NO_ACT  = 3'd4;

  localparam logic [6:0] NO_RULE = 7'd64;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  typedef enum logic [1:0] {
    JOB_WRITE,
    JOB_READ,
    JOB_CLASSIFY,
    JOB_EARLY
  } job_kind_t;

  // One request from the front part to the back part.
  typedef struct packed {
    job_kind_t   kind;
    logic [2:0]  reason;
    logic        icmp;
    logic [2:0]  table_select;
    logic [3:0]  entry_slot;
    logic [31:0] entry_key;
    logic [63:0] entry_bitmap;
    logic        entry_valid;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_ACTION,
    BK_COUNT,
    BK_INC,
    BK_READ,
    BK_OUT
  } back_state_t;

endpackage

/* rtl/bvpc_front.sv */
module bvpc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_func,
  input  logic [7:0]      in_data_byte,
  input  logic            in_last_byte,
  input  logic [2:0]      in_table_select,
  input  logic [3:0]      in_entry_slot,
  input  logic [31:0]     in_entry_key,
  input  logic [63:0]     in_entry_bitmap,
  input  logic            in_entry_valid,
  output logic            job_valid,
  input  logic            job_ready,
  output bvpc_pkg::job_t  job
);
  import bvpc_pkg::*;

  logic [6:0]  pos_r, pos_nxt;
  logic [15:0] eth_r, eth_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] sa_r, sa_nxt, da_r, da_nxt;
  logic [15:0] sp_r, sp_nxt, dp_r, dp_nxt;
  logic        acc;
  logic [7:0]  len;
  logic [2:0]  reason;
  logic        early;

  assign in_ready = job_ready;
  assign acc      = in_valid && in_ready;
  assign len      = {1'b0, pos_r} + 8'd1;

  always_comb begin
    eth_nxt   = eth_r;
    proto_nxt = proto_r;
    sa_nxt    = sa_r;
    da_nxt    = da_r;
    sp_nxt    = sp_r;
    dp_nxt    = dp_r;
    case (pos_r)
      7'd12, 7'd13: eth_nxt = {eth_r[7:0], in_data_byte};
      7'd23: proto_nxt = in_data_byte;
      7'd26, 7'd27, 7'd28, 7'd29: sa_nxt = {sa_r[23:0], in_data_byte};
      7'd30, 7'd31, 7'd32, 7'd33: da_nxt = {da_r[23:0], in_data_byte};
      7'd34, 7'd35: sp_nxt = {sp_r[7:0], in_data_byte};
      7'd36, 7'd37: dp_nxt = {dp_r[7:0], in_data_byte};
      default: ;
    endcase
  end

  always_comb begin
    early  = 1'b1;
    reason = REASON_SHORT;
    if (len < 8'd14) begin
      reason = REASON_SHORT;
    end else if (eth_nxt != 16'h0800) begin
      reason = REASON_NOT_IP;
    end else if (len < 8'd34) begin
      reason = REASON_SHORT;
    end else if (proto_nxt != PROTO_ICMP && proto_nxt != PROTO_TCP &&
                 proto_nxt != PROTO_UDP) begin
      reason = REASON_PROTO;
    end else if (proto_nxt == PROTO_TCP && len < 8'd54) begin
      reason = REASON_SHORT;
    end else if (proto_nxt == PROTO_UDP && len < 8'd42) begin
      reason = REASON_SHORT;
    end else begin
      early = 1'b0;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (acc && in_func == FUNC_BYTE) begin
      if (in_last_byte) begin
        pos_nxt = '0;
      end else if (pos_r != 7'd127) begin
        pos_nxt = pos_r + 7'd1;
      end
    end
  end

  always_comb begin
    job_valid        = 1'b0;
    job              = '0;
    job.table_select = in_table_select;
    job.entry_slot   = in_entry_slot;
    job.entry_key    = in_entry_key;
    job.entry_bitmap = in_entry_bitmap;
    job.entry_valid  = in_entry_valid;
    job.src_addr     = sa_nxt;
    job.dst_addr     = da_nxt;
    job.protocol     = proto_nxt;
    job.src_port     = sp_nxt;
    job.dst_port     = dp_nxt;
    job.icmp         = (proto_nxt == PROTO_ICMP);
    job.reason       = reason;
    job.kind         = early ? JOB_EARLY : JOB_CLASSIFY;
    case (in_func)
      FUNC_BYTE: job_valid = in_valid && in_last_byte;
      FUNC_WRITE: begin
        job_valid = in_valid;
        job.kind  = JOB_WRITE;
      end
      FUNC_READ: begin
        job_valid = in_valid;
        job.kind  = JOB_READ;
      end
      default: job_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      eth_r   <= '0;
      proto_r <= '0;
      sa_r    <= '0;
      da_r    <= '0;
      sp_r    <= '0;
      dp_r    <= '0;
    end else begin
      pos_r <= pos_nxt;
      if (acc && in_func == FUNC_BYTE) begin
        eth_r   <= eth_nxt;
        proto_r <= proto_nxt;
        sa_r    <= sa_nxt;
        da_r    <= da_nxt;
        sp_r    <= sp_nxt;
        dp_r    <= dp_nxt;
      end
    end
  end

endmodule

/* rtl/bvpc_queue.sv */
module bvpc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  bvpc_pkg::job_t  wr_job,
  output logic            rd_valid,
  input  logic            rd_ready,
  output bvpc_pkg::job_t  rd_job
);
  import bvpc_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  job_t            mem_r [QueueDepth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0]   cnt_r;
  logic            push, pop;

  assign wr_ready = (cnt_r != PtrW'(0) + (PtrW+1)'(QueueDepth));
  assign rd_valid = (cnt_r != '0);
  assign rd_job   = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + PtrW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + PtrW'(1);
      end
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

/* rtl/bvpc_back.sv */
module bvpc_back #(
  parameter int unsigned TABLE_ENTRIES = bvpc_pkg::TableEntriesDef,
  parameter int unsigned RULE_BITS     = bvpc_pkg::RuleBitsDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  output logic            job_ready,
  input  bvpc_pkg::job_t  job,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_result_kind,
  output logic            out_drop,
  output logic [2:0]      out_pass_reason,
  output logic [6:0]      out_matched_rule,
  output logic [63:0]     out_counter_value
);
  import bvpc_pkg::*;

  localparam int unsigned SlotW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned Depth  = NumTables * TABLE_ENTRIES;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam logic [63:0] RMask  = (RULE_BITS >= 64) ? {64{1'b1}} :
                                   ((64'd1 << RULE_BITS) - 64'd1);

  // Field tables: one entry is read a cycle while the tables are searched.
  logic [31:0]  key_mem   [Depth];
  logic [63:0]  bmp_mem   [Depth];
  logic [Depth-1:0] ent_v_r;
  logic [NumRules-1:0] act_r;
  // A hit counter whose bit here is clear reads as zero.
  logic [NumRules-1:0] cnt_v_r;
  logic [63:0]  cnt_mem [NumRules];

  back_state_t st_r, st_nxt;
  job_t        job_r;
  logic [2:0]  tbl_r;
  logic [SlotW:0] slot_r;
  logic [AddrW-1:0] ra;
  logic [31:0] rd_key_r;
  logic [63:0] rd_bmp_r;
  logic        rd_v_r, rd_pend_r;
  logic        hit_r, zhit_r;
  logic [63:0] hbm_r, zbm_r;
  logic        miss_r;
  logic [63:0] acc_r;
  logic [6:0]  rule_r;
  logic [63:0] cntv_r;
  logic        cnt_ok_r;
  logic [6:0]  cnt_ra;
  logic        cnt_re, cnt_we;
  logic        okind_r, odrop_r;
  logic [2:0]  oreason_r;
  logic [6:0]  orule_r;
  logic [63:0] ocnt_r;
  logic        ovalid_r;
  logic [31:0] cur_val;
  logic [2:0]  last_tbl;
  logic        tbl_done;
  logic [63:0] tbl_bm;
  logic        tbl_ok;
  logic [6:0]  low;
  logic        in_fire;
  logic        wr_tbl, wr_act;
  logic [AddrW-1:0] wa;

  assign job_ready = (st_r == BK_IDLE);
  assign in_fire   = job_valid && job_ready;
  assign last_tbl  = job_r.icmp ? SEL_PROTO : SEL_DST_PORT;
  assign ra        = AddrW'(tbl_r) * AddrW'(TABLE_ENTRIES) + AddrW'(slot_r[SlotW-1:0]);
  assign wa        = AddrW'(job.table_select) * AddrW'(TABLE_ENTRIES) +
                     AddrW'(job.entry_slot);
  assign wr_tbl    = in_fire && job.kind == JOB_WRITE && job.table_select < 3'(NumTables)
                     && 32'(job.entry_slot) < TABLE_ENTRIES;
  assign wr_act    = in_fire && job.kind == JOB_WRITE && job.table_select == SEL_ACTION
                     && job.entry_key < 32'(NumRules);
  assign cnt_ra    = (st_r == BK_COUNT) ? low : job_r.entry_key[6:0];
  assign cnt_re    = (st_r == BK_COUNT) || (st_r == BK_READ);
  assign cnt_we    = (st_r == BK_INC) && act_r[rule_r];

  always_comb begin
    case (tbl_r)
      SEL_SRC_ADDR: cur_val = job_r.src_addr;
      SEL_DST_ADDR: cur_val = job_r.dst_addr;
      SEL_PROTO:    cur_val = {24'd0, job_r.protocol};
      SEL_SRC_PORT: cur_val = {16'd0, job_r.src_port};
      default:      cur_val = {16'd0, job_r.dst_port};
    endcase
  end

  assign tbl_done = !rd_pend_r && (32'(slot_r) == TABLE_ENTRIES);
  assign tbl_ok   = hit_r || zhit_r;
  assign tbl_bm   = hit_r ? hbm_r : zbm_r;

  always_comb begin
    low = NO_RULE;
    for (int b = 63; b >= 0; b--) begin
      if (acc_r[b]) begin
        low = 7'(b);
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: begin
        if (in_fire) begin
          case (job.kind)
            JOB_CLASSIFY: st_nxt = BK_SEARCH;
            JOB_READ:     st_nxt = BK_READ;
            JOB_EARLY:    st_nxt = BK_OUT;
            default:      st_nxt = BK_IDLE;
          endcase
        end
      end
      BK_SEARCH: if (tbl_done && tbl_r == last_tbl) st_nxt = BK_ACTION;
      BK_ACTION: st_nxt = BK_COUNT;
      BK_COUNT:  st_nxt = BK_INC;
      BK_INC:    st_nxt = BK_OUT;
      BK_READ:   st_nxt = BK_OUT;
      BK_OUT:    if (!ovalid_r || out_ready) st_nxt = BK_IDLE;
      default:   st_nxt = BK_IDLE;
    endcase
  end

  assign out_valid         = ovalid_r;
  assign out_result_kind   = okind_r;
  assign out_drop          = odrop_r;
  assign out_pass_reason   = oreason_r;
  assign out_matched_rule  = orule_r;
  assign out_counter_value = ocnt_r;

  always_ff @(posedge clk) begin
    if (wr_tbl) begin
      key_mem[wa] <= job.entry_key;
      bmp_mem[wa] <= job.entry_bitmap & RMask;
    end
    rd_key_r <= key_mem[ra];
    rd_bmp_r <= bmp_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[rule_r] <= (cnt_ok_r ? cntv_r : 64'd0) + 64'd1;
    end
    if (cnt_re) begin
      cntv_r <= cnt_mem[cnt_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= BK_IDLE;
      ent_v_r   <= '0;
      act_r     <= '0;
      cnt_v_r   <= '0;
      ovalid_r  <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ovalid_r && out_ready) ovalid_r <= 1'b0;
      if (wr_tbl) ent_v_r[wa] <= job.entry_valid;
      if (wr_act) begin
        act_r[job.entry_key[6:0]]   <= job.entry_valid;
        cnt_v_r[job.entry_key[6:0]] <= 1'b0;
      end
      if (in_fire) begin
        job_r     <= job;
        tbl_r     <= SEL_SRC_ADDR;
        slot_r    <= '0;
        rd_pend_r <= 1'b0;
        hit_r     <= 1'b0;
        zhit_r    <= 1'b0;
        miss_r    <= 1'b0;
        acc_r     <= {64{1'b1}};
      end
      if (st_r == BK_SEARCH) begin
        if (rd_pend_r && rd_v_r) begin
          if (!hit_r && rd_key_r == cur_val) begin
            hit_r <= 1'b1;
            hbm_r <= rd_bmp_r;
          end
          if (!zhit_r && rd_key_r == 32'd0) begin
            zhit_r <= 1'b1;
            zbm_r  <= rd_bmp_r;
          end
        end
        if (tbl_done) begin
          if (tbl_ok) acc_r <= acc_r & tbl_bm;
          else        miss_r <= 1'b1;
          tbl_r     <= tbl_r + 3'd1;
          slot_r    <= '0;
          rd_pend_r <= 1'b0;
          hit_r     <= 1'b0;
          zhit_r    <= 1'b0;
        end else if (32'(slot_r) < TABLE_ENTRIES) begin
          rd_v_r    <= ent_v_r[ra];
          rd_pend_r <= 1'b1;
          slot_r    <= slot_r + (SlotW+1)'(1);
        end else begin
          rd_pend_r <= 1'b0;
        end
      end
      if (st_r == BK_ACTION) begin
        if (miss_r) acc_r <= 64'd1;
      end
      if (st_r == BK_COUNT) begin
        rule_r   <= low;
        cnt_ok_r <= cnt_v_r[low];
      end
      if (st_r == BK_INC) begin
        if (act_r[rule_r]) cnt_v_r[rule_r] <= 1'b1;
      end
      if (st_r == BK_READ) begin
        cnt_ok_r <= (job_r.entry_key < 32'(NumRules)) ? cnt_v_r[job_r.entry_key[6:0]] : 1'b0;
      end
      if (st_r == BK_OUT && (!ovalid_r || out_ready)) begin
        ovalid_r <= 1'b1;
        case (job_r.kind)
          JOB_READ: begin
            okind_r <= 1'b1; odrop_r <= 1'b0; oreason_r <= REASON_DROP;
            orule_r <= '0;   ocnt_r  <= cnt_ok_r ? cntv_r : 64'd0;
          end
          JOB_EARLY: begin
            okind_r <= 1'b0; odrop_r <= 1'b0; oreason_r <= job_r.reason;
            orule_r <= NO_RULE; ocnt_r <= '0;
          end
          default: begin
            okind_r   <= 1'b0;
            odrop_r   <= act_r[rule_r];
            oreason_r <= act_r[rule_r] ? REASON_DROP : REASON_NO_ACT;
            orule_r   <= rule_r;
            ocnt_r    <= '0;
          end
        endcase
      end
    end
  end

endmodule

/* rtl/bitvector_packet_classifier_top.sv */
// Last packet bytes, table writes and counter reads enter a two-deep queue; other bytes
// are only captured. The back part serves one request at a time; input is taken one a
// cycle while the queue has room. Synchronous active-low reset clears positions, captures,
// valid and action bits and all hit counters at once; table contents stay undefined until
// written.
module bitvector_packet_classifier_top #(
  parameter int unsigned TABLE_ENTRIES = bvpc_pkg::TableEntriesDef,
  parameter int unsigned RULE_BITS     = bvpc_pkg::RuleBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [2:0]  in_table_select,
  input  logic [3:0]  in_entry_slot,
  input  logic [31:0] in_entry_key,
  input  logic [63:0] in_entry_bitmap,
  input  logic        in_entry_valid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic        out_drop,
  output logic [2:0]  out_pass_reason,
  output logic [6:0]  out_matched_rule,
  output logic [63:0] out_counter_value
);
  import bvpc_pkg::*;

  job_t f_job, b_job;
  logic f_valid, f_ready, b_valid, b_ready;

  bvpc_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_data_byte, .in_last_byte,
    .in_table_select, .in_entry_slot, .in_entry_key, .in_entry_bitmap, .in_entry_valid,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  bvpc_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_job(f_job),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_job(b_job)
  );

  bvpc_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .RULE_BITS(RULE_BITS)) u_back (
    .clk, .rst_n, .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
    .out_valid, .out_ready, .out_result_kind, .out_drop, .out_pass_reason,
    .out_matched_rule, .out_counter_value
  );

endmodule
